>>> rtl/rdu_pkg.sv
// Package with widths, types and arithmetic helpers for the refraction direction unit.
`default_nettype none

package rdu_pkg;

  localparam int unsigned CW   = 16;
  localparam int unsigned FW   = CW - 2;
  localparam int unsigned PW   = 2 * CW;
  localparam int unsigned XW   = 2 * CW + 2;
  localparam int unsigned DW   = CW + 3;
  localparam int unsigned AW   = CW + 2;
  localparam int unsigned RW   = AW + FW;
  localparam int unsigned RMW  = CW + 2;
  localparam int unsigned NSQ  = (CW + 1) / 2;

  localparam logic signed [DW-1:0] ONE_Q = DW'(1) <<< FW;
  localparam logic signed [XW-1:0] SMAX  = XW'((1 << (CW - 1)) - 1);
  localparam logic signed [XW-1:0] SMIN  = -SMAX - XW'(1);

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    logic [2:0][CW-1:0] prp;
    logic [2:0][CW-1:0] nrm;
  } side_t;

  typedef struct packed {
    logic [RMW-1:0] rem;
    logic [CW-1:0]  root;
    logic [RW-1:0]  rad;
  } sq_t;

  function automatic comp_t sat_c(input logic signed [XW-1:0] v);
    comp_t r;
    if (v > SMAX) begin
      r = SMAX[CW-1:0];
    end else if (v < SMIN) begin
      r = SMIN[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  function automatic sq_t sqrt_step(input sq_t s);
    sq_t              r;
    logic [RMW+1:0]   nxt;
    logic [RMW+1:0]   trial;
    nxt   = {s.rem, s.rad[RW-1 -: 2]};
    trial = (RMW + 2)'({s.root, 2'b01});
    if (nxt >= trial) begin
      r.rem  = RMW'(nxt - trial);
      r.root = {s.root[CW-2:0], 1'b1};
    end else begin
      r.rem  = nxt[RMW-1:0];
      r.root = {s.root[CW-2:0], 1'b0};
    end
    r.rad = {s.rad[RW-3:0], 2'b00};
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rdu_front.sv
// Front pipeline: cosine, tangential term, perpendicular part and radicand.
`default_nettype none

module rdu_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     vld_i,
  input  wire logic [2:0][rdu_pkg::CW-1:0] in_i,
  input  wire logic [2:0][rdu_pkg::CW-1:0] nrm_i,
  input  wire logic [rdu_pkg::CW-1:0]   eta_i,
  output logic                          vld_o,
  output rdu_pkg::side_t                side_o,
  output logic [rdu_pkg::RW-1:0]        rad_o
);

  localparam int unsigned NS = 8;

  logic [NS-1:0] vld_q;

  logic [2:0][rdu_pkg::CW-1:0] in1_q, in2_q, in3_q;
  logic [2:0][rdu_pkg::CW-1:0] n1_q, n2_q, n3_q, n4_q, n5_q, n6_q, n7_q, n8_q;
  logic [rdu_pkg::CW-1:0]      eta1_q, eta2_q, eta3_q, eta4_q;
  logic signed [rdu_pkg::PW-1:0] p1_q [3];
  logic signed [rdu_pkg::PW-1:0] cn3_q [3];
  logic signed [rdu_pkg::PW-1:0] sq7_q [3];
  logic signed [rdu_pkg::PW:0]   et5_q [3];
  logic [2:0][rdu_pkg::CW-1:0] t4_q, p6_q, p7_q, p8_q;
  rdu_pkg::comp_t              cos2_q, cos_d;
  logic [rdu_pkg::AW-1:0]      a8_q, a_d;

  logic signed [rdu_pkg::DW-1:0] dot, ndot, lsq, adiff;

  always_comb begin
    dot = '0;
    lsq = '0;
    for (int i = 0; i < 3; i++) begin
      dot = dot + rdu_pkg::DW'(p1_q[i] >>> rdu_pkg::FW);
      lsq = lsq + rdu_pkg::DW'(sq7_q[i] >>> rdu_pkg::FW);
    end
    ndot = -dot;
    if (ndot > rdu_pkg::ONE_Q) begin
      cos_d = rdu_pkg::ONE_Q[rdu_pkg::CW-1:0];
    end else begin
      cos_d = rdu_pkg::sat_c(rdu_pkg::XW'(ndot));
    end
    adiff = rdu_pkg::ONE_Q - lsq;
    a_d   = (adiff < 0) ? rdu_pkg::AW'(-adiff) : rdu_pkg::AW'(adiff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in1_q  <= in_i;
      n1_q   <= nrm_i;
      eta1_q <= eta_i;
      for (int i = 0; i < 3; i++) begin
        p1_q[i] <= $signed(in_i[i]) * $signed(nrm_i[i]);
      end
      in2_q  <= in1_q;
      n2_q   <= n1_q;
      eta2_q <= eta1_q;
      cos2_q <= cos_d;
      in3_q  <= in2_q;
      n3_q   <= n2_q;
      eta3_q <= eta2_q;
      for (int i = 0; i < 3; i++) begin
        cn3_q[i] <= cos2_q * $signed(n2_q[i]);
      end
      n4_q   <= n3_q;
      eta4_q <= eta3_q;
      for (int i = 0; i < 3; i++) begin
        t4_q[i] <= rdu_pkg::sat_c(rdu_pkg::XW'($signed(in3_q[i]))
                                  + rdu_pkg::XW'(cn3_q[i] >>> rdu_pkg::FW));
      end
      n5_q <= n4_q;
      for (int i = 0; i < 3; i++) begin
        et5_q[i] <= $signed({1'b0, eta4_q}) * $signed(t4_q[i]);
      end
      n6_q <= n5_q;
      for (int i = 0; i < 3; i++) begin
        p6_q[i] <= rdu_pkg::sat_c(rdu_pkg::XW'(et5_q[i] >>> rdu_pkg::FW));
      end
      n7_q <= n6_q;
      p7_q <= p6_q;
      for (int i = 0; i < 3; i++) begin
        sq7_q[i] <= $signed(p6_q[i]) * $signed(p6_q[i]);
      end
      n8_q <= n7_q;
      p8_q <= p7_q;
      a8_q <= a_d;
    end
  end

  assign vld_o      = vld_q[NS-1];
  assign side_o.prp = p8_q;
  assign side_o.nrm = n8_q;
  assign rad_o      = {a8_q, {rdu_pkg::FW{1'b0}}};

endmodule

`default_nettype wire

>>> rtl/rdu_sqrt.sv
// Pipelined digit-by-digit integer square root, two result bits per stage.
`default_nettype none

module rdu_sqrt (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 vld_i,
  input  wire rdu_pkg::side_t       side_i,
  input  wire logic [rdu_pkg::RW-1:0] rad_i,
  output logic                      vld_o,
  output rdu_pkg::side_t            side_o,
  output logic [rdu_pkg::CW-1:0]    root_o
);

  localparam int unsigned NS = rdu_pkg::NSQ;

  logic [NS-1:0]  vld_q;
  rdu_pkg::sq_t   st_q [NS];
  rdu_pkg::sq_t   st_d [NS];
  rdu_pkg::side_t side_q [NS];
  rdu_pkg::sq_t   src;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        src.rem  = '0;
        src.root = '0;
        src.rad  = rad_i;
      end else begin
        src = st_q[s-1];
      end
      st_d[s] = rdu_pkg::sqrt_step(src);
      if (2 * s + 1 < rdu_pkg::CW) begin
        st_d[s] = rdu_pkg::sqrt_step(st_d[s]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= NS'({vld_q, vld_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        st_q[s]   <= st_d[s];
        side_q[s] <= (s == 0) ? side_i : side_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign side_o = side_q[NS-1];
  assign root_o = st_q[NS-1].root;

endmodule

`default_nettype wire

>>> rtl/rdu_back.sv
// Back pipeline: parallel part from the root and the saturated final sum.
`default_nettype none

module rdu_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    vld_i,
  input  wire rdu_pkg::side_t          side_i,
  input  wire logic [rdu_pkg::CW-1:0]  root_i,
  output logic                         vld_o,
  output logic [2:0][rdu_pkg::CW-1:0]  out_o
);

  logic [1:0]                    vld_q;
  logic signed [rdu_pkg::PW:0]   pr_q [3];
  logic [2:0][rdu_pkg::CW-1:0]   perp_q, out_q;
  logic signed [rdu_pkg::XW-1:0] npr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      npr[i] = -rdu_pkg::XW'(pr_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      perp_q <= side_i.prp;
      for (int i = 0; i < 3; i++) begin
        pr_q[i]  <= $signed({1'b0, root_i}) * $signed(side_i.nrm[i]);
        out_q[i] <= rdu_pkg::sat_c(rdu_pkg::XW'($signed(perp_q[i]))
                                   + (npr[i] >>> rdu_pkg::FW));
      end
    end
  end

  assign vld_o = vld_q[1];
  assign out_o = out_q;

endmodule

`default_nettype wire

>>> rtl/refraction_direction_unit_core.sv
// Top level of the refraction direction unit: stream ports and pipeline hookup.
//
// Channel   Direction  Payload (tdata, low bits first)
// s_axis    in         in_x, in_y, in_z, nrm_x, nrm_y, nrm_z, eta_ratio (16 bits each)
// m_axis    out        out_x, out_y, out_z (16 bits each)
//
// One transaction is accepted per cycle unless m_axis stalls. The pipeline has eight front
// stages, eight square-root stages at two root bits each, and two back stages.
// Reset clears only the stage valid bits. A stall on m_axis freezes the whole
// pipeline, and s_axis_tready follows it.
`default_nettype none

module refraction_direction_unit_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,  // in_x, in_y, in_z, nrm_x, nrm_y, nrm_z, eta_ratio
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [47:0]       m_axis_tdata   // out_x, out_y, out_z
);

  localparam int unsigned W = rdu_pkg::CW;

  logic                  en;
  logic                  f_vld, s_vld;
  rdu_pkg::side_t        f_side, s_side;
  logic [rdu_pkg::RW-1:0] f_rad;
  logic [W-1:0]          s_root;
  logic [2:0][W-1:0]     in_v, nrm_v, out_v;

  assign en            = m_axis_tready | ~m_axis_tvalid;
  assign s_axis_tready = en;

  assign in_v  = s_axis_tdata[3*W-1:0];
  assign nrm_v = s_axis_tdata[6*W-1:3*W];

  rdu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .in_i   (in_v),
    .nrm_i  (nrm_v),
    .eta_i  (s_axis_tdata[7*W-1:6*W]),
    .vld_o  (f_vld),
    .side_o (f_side),
    .rad_o  (f_rad)
  );

  rdu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld),
    .side_i (f_side),
    .rad_i  (f_rad),
    .vld_o  (s_vld),
    .side_o (s_side),
    .root_o (s_root)
  );

  rdu_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_vld),
    .side_i (s_side),
    .root_i (s_root),
    .vld_o  (m_axis_tvalid),
    .out_o  (out_v)
  );

  assign m_axis_tdata = out_v;

endmodule

`default_nettype wire
